[rtl/rpc_record_mark_reassembler_core_assert.svh]
// assertion macros for the record mark reassembler
// clocked on clk, disabled while rst_n is low
`ifndef RPC_RECORD_MARK_REASSEMBLER_CORE_ASSERT_SVH
`define RPC_RECORD_MARK_REASSEMBLER_CORE_ASSERT_SVH

// same-cycle implication
`define RPCRM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpcrm assertion failed");

// next-cycle implication
`define RPCRM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpcrm assertion failed");

`endif

[rtl/rpcrm_pkg.sv]
// shared types and constants for the record mark reassembler
// no dependencies
`default_nettype none

package rpcrm_pkg;

    localparam int MARK_BYTES = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [20:0] LIMIT_CAP   = 21'd1048576;
    localparam logic [20:0] LIMIT_RESET = 21'd65536;
    localparam logic [31:0] FINAL_BIT   = 32'h8000_0000;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_OVERSIZE = 2'd2,
        KIND_CLOSED   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [19:0] write_offset;
        logic [19:0] total_length;
        logic [31:0] header_word;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic       dead;
        logic [1:0] res_count;
    } rpcrm_status_t;

    function automatic result_t res_simple(input kind_t k);
        result_t r;
        r              = '0;
        r.kind         = k;
        r.last_of_run  = 1'b1;
        return r;
    endfunction

    function automatic result_t res_complete(input logic [20:0] total);
        result_t r;
        r              = '0;
        r.kind         = KIND_COMPLETE;
        r.total_length = total[19:0];
        r.header_word  = FINAL_BIT | {11'd0, total};
        r.last_of_run  = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/rpcrm_deframer.sv]
// record mark parser and message state, one byte per step
// depends on rpcrm_pkg
`default_nettype none

module rpcrm_deframer (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   fire,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   link_closed,
    input  wire logic [20:0]            limit,
    output rpcrm_pkg::result_t          res0,
    output rpcrm_pkg::result_t          res1,
    output rpcrm_pkg::rpcrm_status_t    status
);
    import rpcrm_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_DEAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] mark_shift_reg, mark_shift_next;
    logic [1:0]  mark_seen_reg, mark_seen_next;
    logic [20:0] remaining_reg, remaining_next;
    logic        final_reg, final_next;
    logic [20:0] total_reg, total_next;
    logic [20:0] offset_reg, offset_next;

    logic [31:0] shifted;
    logic [30:0] frag_len;
    logic [31:0] need;
    logic [20:0] total_sum;
    logic [20:0] rem_dec;
    logic [1:0]  count;

    always_comb
    begin
        shifted   = {mark_shift_reg[23:0], data_byte};
        frag_len  = shifted[30:0];
        need      = {11'd0, total_reg} + {1'b0, frag_len} + 32'(MARK_BYTES);
        total_sum = total_reg + frag_len[20:0];
        rem_dec   = (remaining_reg != 21'd0) ? remaining_reg - 21'd1 : 21'd0;

        phase_next      = phase_reg;
        mark_shift_next = mark_shift_reg;
        mark_seen_next  = mark_seen_reg;
        remaining_next  = remaining_reg;
        final_next      = final_reg;
        total_next      = total_reg;
        offset_next     = offset_reg;
        res0            = '0;
        res1            = '0;
        count           = 2'd0;

        if (phase_reg != PH_DEAD)
        begin
            if (link_closed)
            begin
                res0       = res_simple(KIND_CLOSED);
                count      = 2'd1;
                phase_next = PH_DEAD;
            end
            else if (phase_reg == PH_HEADER)
            begin
                mark_shift_next = shifted;
                mark_seen_next  = mark_seen_reg + 2'd1;
                if (mark_seen_reg == 2'(MARK_BYTES - 1))
                begin
                    mark_seen_next = 2'd0;
                    if (need > {11'd0, limit})
                    begin
                        res0       = res_simple(KIND_OVERSIZE);
                        count      = 2'd1;
                        phase_next = PH_DEAD;
                    end
                    else
                    begin
                        final_next      = shifted[31];
                        total_next      = total_sum;
                        remaining_next  = frag_len[20:0];
                        mark_shift_next = '0;
                        if (frag_len != 31'd0)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                        else if (shifted[31])
                        begin
                            // empty final fragment completes at once
                            res0           = res_complete(total_sum);
                            count          = 2'd1;
                            final_next     = 1'b0;
                            total_next     = '0;
                            remaining_next = '0;
                            offset_next    = 21'(MARK_BYTES);
                        end
                    end
                end
            end
            else
            begin
                res0.kind         = KIND_PAYLOAD;
                res0.payload_byte = data_byte;
                res0.write_offset = offset_reg[19:0];
                res0.last_of_run  = 1'b1;
                count             = 2'd1;
                offset_next       = offset_reg + 21'd1;
                remaining_next    = rem_dec;
                if (rem_dec == 21'd0)
                begin
                    phase_next = PH_HEADER;
                    if (final_reg)
                    begin
                        res0.last_of_run = 1'b0;
                        res1             = res_complete(total_reg);
                        count            = 2'd2;
                        final_next       = 1'b0;
                        total_next       = '0;
                        offset_next      = 21'(MARK_BYTES);
                        mark_shift_next  = '0;
                        mark_seen_next   = '0;
                    end
                end
            end
        end

        status.dead      = (phase_reg == PH_DEAD);
        status.res_count = fire ? count : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            mark_shift_reg <= '0;
            mark_seen_reg  <= '0;
            remaining_reg  <= '0;
            final_reg      <= 1'b0;
            total_reg      <= '0;
            offset_reg     <= 21'(MARK_BYTES);
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            mark_shift_reg <= mark_shift_next;
            mark_seen_reg  <= mark_seen_next;
            remaining_reg  <= remaining_next;
            final_reg      <= final_next;
            total_reg      <= total_next;
            offset_reg     <= offset_next;
        end
    end

endmodule

`default_nettype wire

[rtl/rpcrm_result_fifo.sv]
// result queue taking up to two results per cycle, one out per transfer
// depends on rpcrm_pkg
`default_nettype none

module rpcrm_result_fifo (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [1:0]                 push_count,
    input  wire rpcrm_pkg::result_t         push0,
    input  wire rpcrm_pkg::result_t         push1,
    input  wire logic                       pop,
    output rpcrm_pkg::result_t              head,
    output logic [rpcrm_pkg::FIFO_AW:0]     count
);
    import rpcrm_pkg::*;

    result_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               do_pop;

    assign do_pop      = pop && (count_reg != '0);
    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_count);
    assign head        = mem[rd_ptr_reg];
    assign count       = count_reg;

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem[wr_ptr_reg + FIFO_AW'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_reg + (FIFO_AW + 1)'(push_count)
                       - (FIFO_AW + 1)'(do_pop);
        end
    end

endmodule

`default_nettype wire

[rtl/rpc_record_mark_reassembler_core.sv]
// top level: input register, deframer, result queue and limit register
// depends on rpcrm_pkg, rpcrm_deframer, rpcrm_result_fifo
// a transferred byte passes the input register and then the result queue before its first result can be transferred
// throughput: one byte per cycle while the queue has room; a byte ending a final fragment gives two results
// input stalls while the four-entry queue cannot take two more results
// reset: asynchronous active-low rst_n clears parser and queue, limit back to 65536
`default_nettype none

module rpc_record_mark_reassembler_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tuser,   // link_closed
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // payload_byte, write_offset, total_length, header_word
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast,   // last_of_run
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [20:0] cfg_data   // max_message_bytes
);
    `include "rpc_record_mark_reassembler_core_assert.svh"
    import rpcrm_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_closed_reg;
    logic [20:0] limit_reg;
    logic [20:0] limit;

    result_t          res0, res1, head;
    rpcrm_status_t    status;
    logic [FIFO_AW:0] fifo_count;
    logic             pop;
    logic             room;
    logic             fire;

    assign limit     = (limit_reg > LIMIT_CAP) ? LIMIT_CAP : limit_reg;
    assign pop       = m_tvalid && m_tready;
    assign room      = (fifo_count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2))
                    || (pop && fifo_count == (FIFO_AW + 1)'(FIFO_DEPTH - 1));
    assign fire      = in_valid_reg && room;
    assign s_tready  = !in_valid_reg || room;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            limit_reg    <= LIMIT_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg   <= s_tdata;
            in_closed_reg <= s_tuser;
        end
    end

    rpcrm_deframer u_deframer (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .data_byte   (in_byte_reg),
        .link_closed (in_closed_reg),
        .limit       (limit),
        .res0        (res0),
        .res1        (res1),
        .status      (status)
    );

    rpcrm_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (status.res_count),
        .push0      (res0),
        .push1      (res1),
        .pop        (pop),
        .head       (head),
        .count      (fifo_count)
    );

    assign m_tvalid = (fifo_count != '0);
    assign m_tdata  = {head.header_word, head.total_length,
                       head.write_offset, head.payload_byte};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last_of_run;

    `RPCRM_ASSERT_NXT(a_dead_sticks, status.dead, status.dead)
    `RPCRM_ASSERT_IMP(a_pair_shape, status.res_count == 2'd2,
        res0.kind == KIND_PAYLOAD && res1.kind == KIND_COMPLETE && !res0.last_of_run)
    `RPCRM_ASSERT_IMP(a_no_overflow, 1'b1, fifo_count <= (FIFO_AW + 1)'(FIFO_DEPTH))
    `RPCRM_ASSERT_IMP(a_dead_silent, status.dead, status.res_count == 2'd0)

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// testbench for rpc_record_mark_reassembler_core: feeds record-marked byte streams,
// rebuilds the payload, completion and error results in a local deframer and checks
// every output transfer field by field; depends on rpcrm_pkg and the core rtl

module tb;
    import rpcrm_pkg::*;

    typedef enum logic [1:0] {ST_MARK, ST_BODY, ST_DEAD} parse_state_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // data_byte
    logic        s_tuser;    // link_closed
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;    // payload_byte, write_offset, total_length, header_word
    logic [1:0]  m_tuser;    // kind
    logic        m_tlast;    // last_of_run
    logic        cfg_valid;
    logic        cfg_ready;
    logic [20:0] cfg_data;   // max_message_bytes

    parse_state_t parse_state;
    logic [31:0]  mark_word;
    int           mark_count;
    logic [20:0]  frag_left;
    logic         frag_is_final;
    logic [20:0]  msg_total;
    logic [20:0]  next_wr_offset;
    logic [20:0]  max_msg_bytes;

    result_t due_results[$];
    int      error_count = 0;
    int      idle_pct;
    int      stall_pct;
    int      bytes_sent = 0;

    rpc_record_mark_reassembler_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic result_t make_result(input kind_t k, input logic [7:0] b,
                                            input logic [19:0] ofs, input logic [20:0] total);
        result_t r;
        r              = '0;
        r.kind         = k;
        r.payload_byte = b;
        r.write_offset = ofs;
        if (k == KIND_COMPLETE)
        begin
            r.total_length = total[19:0];
            r.header_word  = {11'd0, total} | FINAL_BIT;
        end
        return r;
    endfunction

    function automatic void restart_message();
        parse_state    = ST_MARK;
        mark_word      = '0;
        mark_count     = 0;
        frag_left      = '0;
        frag_is_final  = 1'b0;
        msg_total      = '0;
        next_wr_offset = 21'(MARK_BYTES);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic closed);
        result_t         step_out[$];
        logic [30:0]     flen;
        logic [20:0]     eff_limit;
        longint unsigned need;
        if (parse_state == ST_DEAD)
            return;
        if (closed)
        begin
            step_out.push_back(make_result(KIND_CLOSED, 8'd0, 20'd0, 21'd0));
            parse_state = ST_DEAD;
        end
        else if (parse_state == ST_MARK)
        begin
            mark_word = {mark_word[23:0], b};
            mark_count++;
            if (mark_count == MARK_BYTES)
            begin
                mark_count = 0;
                flen       = mark_word[30:0];
                eff_limit  = (max_msg_bytes > LIMIT_CAP) ? LIMIT_CAP : max_msg_bytes;
                need       = 64'(msg_total) + 64'(flen) + 64'(MARK_BYTES);
                if (need > 64'(eff_limit))
                begin
                    step_out.push_back(make_result(KIND_OVERSIZE, 8'd0, 20'd0, 21'd0));
                    parse_state = ST_DEAD;
                end
                else
                begin
                    frag_is_final = mark_word[31];
                    msg_total     = msg_total + flen[20:0];
                    frag_left     = flen[20:0];
                    mark_word     = '0;
                    if (flen == 0)
                    begin
                        if (frag_is_final)
                        begin
                            step_out.push_back(make_result(KIND_COMPLETE, 8'd0, 20'd0, msg_total));
                            restart_message();
                        end
                    end
                    else
                        parse_state = ST_BODY;
                end
            end
        end
        else
        begin
            step_out.push_back(make_result(KIND_PAYLOAD, b, next_wr_offset[19:0], 21'd0));
            next_wr_offset = next_wr_offset + 21'd1;
            if (frag_left > 0)
                frag_left = frag_left - 21'd1;
            if (frag_left == 0)
            begin
                if (frag_is_final)
                begin
                    step_out.push_back(make_result(KIND_COMPLETE, 8'd0, 20'd0, msg_total));
                    restart_message();
                end
                else
                    parse_state = ST_MARK;
            end
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last_of_run = 1'b1;
        foreach (step_out[i])
            due_results.push_back(step_out[i]);
    endfunction

    task automatic report_error(input string what, input longint unsigned got,
                                input longint unsigned want);
        error_count++;
        $display("ERROR %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_results.size() == 0)
                report_error("result with nothing due, kind", m_tuser, 0);
            else
            begin
                want = due_results.pop_front();
                if (m_tuser !== want.kind)
                    report_error("kind", m_tuser, want.kind);
                if (m_tdata[7:0] !== want.payload_byte)
                    report_error("payload_byte", m_tdata[7:0], want.payload_byte);
                if (m_tdata[27:8] !== want.write_offset)
                    report_error("write_offset", m_tdata[27:8], want.write_offset);
                if (m_tdata[47:28] !== want.total_length)
                    report_error("total_length", m_tdata[47:28], want.total_length);
                if (m_tdata[79:48] !== want.header_word)
                    report_error("header_word", m_tdata[79:48], want.header_word);
                if (m_tlast !== want.last_of_run)
                    report_error("last_of_run", m_tlast, want.last_of_run);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic closed);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= closed;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        deframe_byte(b, closed);
        bytes_sent++;
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_limit(input logic [20:0] value);
        hold_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        max_msg_bytes = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_mark(input logic final_flag, input logic [30:0] len);
        logic [31:0] word;
        word = {final_flag, len};
        for (int i = 3; i >= 0; i--)
            send_byte(word[i*8 +: 8], 1'b0);
    endtask

    task automatic send_fragment(input logic final_flag, input int len);
        send_mark(final_flag, 31'(len));
        repeat (len) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic send_random_message();
        int nfrag;
        int budget;
        int flen;
        budget = ((max_msg_bytes > LIMIT_CAP) ? int'(LIMIT_CAP) : int'(max_msg_bytes)) - MARK_BYTES;
        nfrag  = $urandom_range(1, 3);
        for (int i = 1; i <= nfrag; i++)
        begin
            case ($urandom_range(15))
                0, 1:    flen = 0;
                2:       flen = budget;
                3:       flen = $urandom_range(13, 200);
                default: flen = $urandom_range(1, 12);
            endcase
            if (flen > budget)
                flen = budget;
            if (flen > 300)
                flen = $urandom_range(1, 12);
            budget -= flen;
            send_fragment(i == nfrag, flen);
        end
    endtask

    task automatic test_directed_framing();
        idle_pct  = 0;
        stall_pct = 0;
        send_fragment(1'b1, 0);
        send_fragment(1'b0, 0);
        send_mark(1'b1, 31'd1);
        send_byte(8'hff, 1'b0);
        send_mark(1'b0, 31'd2);
        send_byte(8'h00, 1'b0);
        send_byte(8'ha5, 1'b0);
        send_mark(1'b1, 31'd1);
        send_byte(8'h5a, 1'b0);
    endtask

    task automatic test_limit_extremes();
        write_limit(21'd4);
        send_fragment(1'b0, 0);
        send_fragment(1'b1, 0);
        send_fragment(1'b1, 0);
        write_limit(21'd5);
        send_fragment(1'b1, 1);
        send_fragment(1'b0, 0);
        send_fragment(1'b1, 1);
    endtask

    task automatic test_traffic_phase(input logic [20:0] limit, input int idle,
                                      input int stall, input int n_bytes);
        int target;
        write_limit(limit);
        idle_pct  = idle;
        stall_pct = stall;
        target    = bytes_sent + n_bytes;
        while (bytes_sent < target)
            send_random_message();
    endtask

    task automatic test_dead_state();
        idle_pct  = 6;
        stall_pct = 6;
        case ($urandom_range(3))
            0:
            begin
                // oversize found at the second mark of a message
                write_limit(21'd40);
                send_fragment(1'b0, 10);
                send_mark(1'b0, 31'd27);
            end
            1:
            begin
                // limit above range clamps to the cap
                write_limit(21'h1fffff);
                send_mark(1'b0, 31'd1048573);
            end
            2:
            begin
                send_byte(8'h80, 1'b0);
                send_byte(8'h00, 1'b0);
                send_byte(8'($urandom_range(255)), 1'b1);
            end
            default:
            begin
                send_mark(1'b1, 31'd5);
                repeat (2) send_byte(8'($urandom_range(255)), 1'b0);
                send_byte(8'($urandom_range(255)), 1'b1);
            end
        endcase
        repeat (20) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 21'd0;
        idle_pct  = 0;
        stall_pct = 0;
        max_msg_bytes = LIMIT_RESET;
        restart_message();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_framing();
        test_limit_extremes();
        test_traffic_phase(LIMIT_RESET, 0, 0, 90);
        test_traffic_phase(21'd40, 73, 0, 80);
        test_traffic_phase(21'd5, 0, 73, 70);
        test_traffic_phase(21'h1fffff, 6, 6, 80);
        test_traffic_phase(LIMIT_CAP, 0, 0, 40);
        test_dead_state();

        hold_until_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
